FILE: sv/card_balance_ledger_unit_assert.svh
// assertion macros of the card balance ledger, used by its datapath module
`ifndef CARD_BALANCE_LEDGER_UNIT_ASSERT_SVH
`define CARD_BALANCE_LEDGER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CBL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CBL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cbl_pkg.sv
// types, constants and helpers of the card balance ledger
package cbl_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int EIDX_W      = 6;
    localparam int CFG_IDX_W   = 1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BAL_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAL_MAX = 1'b1;

    // reset values of the limits
    localparam logic signed [31:0] BAL_MIN_RST = 32'sd0;
    localparam logic signed [31:0] BAL_MAX_RST = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic        [31:0] card_id;
        logic signed [31:0] amount;
    } t_cbl_req;

    typedef struct packed {
        logic        [1:0]        status;
        logic signed [31:0]       balance;
        logic        [EIDX_W-1:0] entry_index;
        logic                     new_card;
    } t_cbl_rsp;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic hit_load;
        logic miss_load;
        logic sum;
        logic finish;
    } t_cbl_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic exhausted;
        logic out_free;
    } t_cbl_sts;

    // low bits of a slot number as reported on the result
    function automatic logic [EIDX_W-1:0] f_entry_index(input logic [IDX_W-1:0] slot);
        logic [EIDX_W+IDX_W-1:0] wide;
        wide = {{EIDX_W{1'b0}}, slot};
        return wide[EIDX_W-1:0];
    endfunction

endpackage

FILE: sv/cbl_ctrl.sv
// sequencing state machine of the card balance ledger
module cbl_ctrl
    import cbl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_cbl_sts i_sts,
    output t_cbl_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd.hit_load = 1'b1;
                    n_state        = S_ADD;
                end else if (i_sts.exhausted) begin
                    o_cmd.miss_load = 1'b1;
                    n_state         = S_ADD;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_ADD: begin
                o_cmd.sum = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/cbl_dp.sv
// table memory, search pipeline, balance arithmetic and result register
`include "card_balance_ledger_unit_assert.svh"

module cbl_dp
    import cbl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cbl_req              i_req,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  t_cbl_cmd              i_cmd,
    output t_cbl_sts              o_sts,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    output t_cbl_rsp              o_rsp
);

    // table word: card id above balance
    logic [63:0]             r_mem [TABLE_DEPTH];

    t_cbl_req                r_req;
    logic [CNT_W-1:0]        r_addr;
    logic                    r_rd_vld;
    logic [IDX_W-1:0]        r_rd_addr;
    logic [63:0]             r_rd_word;
    logic [IDX_W-1:0]        r_slot;
    logic signed [31:0]      r_bal;
    logic                    r_new;
    logic                    r_full;
    logic signed [32:0]      r_sum;
    logic [CNT_W-1:0]        r_count;
    logic signed [31:0]      r_min;
    logic signed [31:0]      r_max;
    t_cbl_rsp                r_rsp;
    logic                    r_rsp_vld;

    logic                    more;
    logic                    in_range;
    logic signed [31:0]      new_bal;

    assign more = (r_addr < r_count);

    // status toward the controller
    assign o_sts.hit       = r_rd_vld && (r_rd_word[63:32] == r_req.card_id);
    assign o_sts.exhausted = !r_rd_vld && !more;
    assign o_sts.out_free  = !r_rsp_vld || i_rsp_ready;

    // range check on the widened sum
    assign in_range = !(r_sum < $signed({r_min[31], r_min}))
                   && !(r_sum > $signed({r_max[31], r_max}));
    assign new_bal  = in_range ? r_sum[31:0] : r_bal;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= BAL_MIN_RST;
            r_max <= BAL_MAX_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BAL_MIN: r_min <= i_cfg_data;
                CFG_BAL_MAX: r_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // search control and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_cmd.start) begin
                r_addr   <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_vld <= more;
                if (more) begin
                    r_addr <= r_addr + 1'b1;
                end
            end
            if (i_cmd.miss_load && (r_count != CNT_W'(TABLE_DEPTH))) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // table memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && more) begin
            r_rd_word <= r_mem[r_addr[IDX_W-1:0]];
            r_rd_addr <= r_addr[IDX_W-1:0];
        end
        if (i_cmd.finish && !r_full) begin
            r_mem[r_slot] <= {r_req.card_id, new_bal};
        end
    end

    // request, matched entry and sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req <= i_req;
        end
        if (i_cmd.hit_load) begin
            r_slot <= r_rd_addr;
            r_bal  <= r_rd_word[31:0];
            r_new  <= 1'b0;
            r_full <= 1'b0;
        end else if (i_cmd.miss_load) begin
            r_slot <= r_count[IDX_W-1:0];
            r_bal  <= '0;
            r_new  <= 1'b1;
            r_full <= (r_count == CNT_W'(TABLE_DEPTH));
        end
        if (i_cmd.sum) begin
            r_sum <= {r_bal[31], r_bal} + {r_req.amount[31], r_req.amount};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_rsp_vld <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_full) begin
                r_rsp <= '{status: ST_FULL, balance: '0, entry_index: '0, new_card: 1'b0};
            end else begin
                r_rsp.status      <= in_range ? ST_OK : ST_RANGE;
                r_rsp.balance     <= new_bal;
                r_rsp.entry_index <= f_entry_index(r_slot);
                r_rsp.new_card    <= r_new;
            end
        end
    end

    assign o_rsp_valid = r_rsp_vld;
    assign o_rsp       = r_rsp;

    // checks
    `CBL_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(TABLE_DEPTH), "fill count past depth")
    `CBL_ASSERT_IMP(a_full_only_when_full, r_rsp_vld && (r_rsp.status == ST_FULL),
        r_count == CNT_W'(TABLE_DEPTH), "table full reported below depth")
    `CBL_ASSERT_IMP(a_no_overwrite, i_cmd.finish, !r_rsp_vld || i_rsp_ready,
        "result overwritten before taken")
    `CBL_ASSERT_NXT(a_insert_counts, i_cmd.miss_load && (r_count != CNT_W'(TABLE_DEPTH)),
        r_count == $past(r_count) + 1'b1, "insert did not advance fill count")

endmodule

FILE: sv/card_balance_ledger_unit.sv
// Card balance ledger: one request (card id, signed amount) at a time. The table is
// searched from slot 0 upward with one memory read per cycle. Each request goes
// through the search, a load of the matched or new entry, the sum and the finish; the
// finish waits while the previous result is held at the output and not yet taken. A
// missing card is appended with balance zero even if the amount is then rejected; with
// the 64-entry table full the result reports table full. Limits are to be written
// through the configuration port only while idle; the block does not enforce this.
module card_balance_ledger_unit
    import cbl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  t_cbl_req             i_req,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_ready,
    output t_cbl_rsp             o_rsp,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_cbl_cmd cmd;
    t_cbl_sts sts;

    // configuration writes always taken
    assign o_cfg_ready = 1'b1;

    // sequencer
    cbl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // table and arithmetic
    cbl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule
